// ===== rtl/mrt_pkg.sv =====
// Types, constants and operator tables shared by the mangling-rule tokenizer.
package mrt_pkg;

   localparam int NUM_OPS = 48;

   typedef enum logic [2:0] {
      PH_OP,
      PH_POS1,
      PH_POS2,
      PH_CHAR1,
      PH_CHAR2,
      PH_COMMENT,
      PH_ERR
   } phase_type;

   typedef enum logic [2:0] {
      SH_NONE,
      SH_P,
      SH_PP,
      SH_C,
      SH_CC,
      SH_PC
   } shape_type;

   localparam logic [1:0] ESC_IDLE  = 2'd0;
   localparam logic [1:0] ESC_SLASH = 2'd1;
   localparam logic [1:0] ESC_HEX0  = 2'd2;
   localparam logic [1:0] ESC_HEX1  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNSUP    = 2'd1;
   localparam logic [1:0] STATUS_MALFORM  = 2'd2;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd3;

   localparam logic [5:0] OP_COLON = 6'd0;
   localparam logic [5:0] OP_NONE  = 6'd48;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] BYTE_CR   = 8'h0D;
   localparam logic [7:0] BYTE_LF   = 8'h0A;
   localparam logic [7:0] BYTE_NUL  = 8'h00;

   localparam logic [7:0] OP_BYTE [NUM_OPS] = '{
      8'h3A, 8'h6C, 8'h75, 8'h63, 8'h72, 8'h64, 8'h5B, 8'h5D,
      8'h54, 8'h74, 8'h24, 8'h5E, 8'h44, 8'h2B, 8'h2D, 8'h2E,
      8'h2C, 8'h2A, 8'h4C, 8'h52, 8'h7B, 8'h7D, 8'h6B, 8'h4B,
      8'h71, 8'h73, 8'h45, 8'h66, 8'h6F, 8'h69, 8'h4F, 8'h49,
      8'h43, 8'h70, 8'h27, 8'h78, 8'h79, 8'h59, 8'h40, 8'h7A,
      8'h5A, 8'h3C, 8'h3E, 8'h5F, 8'h21, 8'h2F, 8'h28, 8'h29
   };

   localparam shape_type OP_SHAPE [NUM_OPS] = '{
      SH_NONE, SH_NONE, SH_NONE, SH_NONE, SH_NONE, SH_NONE, SH_NONE, SH_NONE,
      SH_P,    SH_NONE, SH_C,    SH_C,    SH_P,    SH_P,    SH_P,    SH_P,
      SH_P,    SH_PP,   SH_P,    SH_P,    SH_NONE, SH_NONE, SH_NONE, SH_NONE,
      SH_NONE, SH_CC,   SH_NONE, SH_NONE, SH_PC,   SH_PC,   SH_PP,   SH_PC,
      SH_NONE, SH_P,    SH_P,    SH_PP,   SH_P,    SH_P,    SH_C,    SH_P,
      SH_P,    SH_P,    SH_P,    SH_P,    SH_C,    SH_C,    SH_C,    SH_C
   };

   typedef struct packed {
      phase_type  phase;
      logic [5:0] pending_op;
      logic [7:0] held_arg;
      logic [7:0] esc_byte;
      logic [1:0] esc_fill;
      logic [1:0] err;
   } line_state_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] op;
      logic [7:0] arg_one;
      logic [7:0] arg_two;
   } token_type;

   typedef struct packed {
      logic       kind;
      logic [5:0] opcode;
      logic [7:0] arg_one;
      logic [7:0] arg_two;
      logic [1:0] status;
      logic       final_res;
   } result_type;

endpackage

// ===== rtl/mrt_feed.sv =====
// One parsing step: applies a single rule byte to the line state and yields at most one token.
module mrt_feed #(
   parameter int MAX_COMMANDS = 32,
   parameter int CNT_W        = 6
) (
   input  mrt_pkg::line_state_type st_i,
   input  logic [CNT_W-1:0]        cnt_i,
   input  logic [7:0]              byte_i,
   input  logic                    last_i,
   output mrt_pkg::line_state_type st_o,
   output logic [CNT_W-1:0]        cnt_o,
   output mrt_pkg::token_type      tok_o,
   output logic                    again_o
);

   logic               do_arg;
   logic [7:0]         arg_v;
   logic [5:0]         op_idx;
   mrt_pkg::shape_type new_shape;
   mrt_pkg::shape_type pend_shape;
   logic [4:0]         hex_hi;
   logic [4:0]         hex_lo;
   logic [7:0]         pos_v;

   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] d;
      d = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = 5'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = 5'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = 5'(b - 8'h37);
      end
      return d;
   endfunction

   always_comb begin
      op_idx = mrt_pkg::OP_NONE;
      for (int k = 0; k < mrt_pkg::NUM_OPS; k++) begin
         if (byte_i == mrt_pkg::OP_BYTE[k]) begin
            op_idx = 6'(k);
         end
      end
   end

   always_comb begin
      pos_v = 8'd0;
      if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
         pos_v = byte_i - 8'h30;
      end else if (byte_i >= 8'h41 && byte_i <= 8'h5A) begin
         pos_v = byte_i - 8'h37;
      end else if (byte_i >= 8'h61 && byte_i <= 8'h7A) begin
         pos_v = byte_i - 8'h57;
      end
   end

   assign hex_hi     = hex_digit(st_i.esc_byte);
   assign hex_lo     = hex_digit(byte_i);
   assign new_shape  = (op_idx < mrt_pkg::OP_NONE) ? mrt_pkg::OP_SHAPE[op_idx] : mrt_pkg::SH_NONE;
   assign pend_shape = mrt_pkg::OP_SHAPE[st_i.pending_op];

   always_comb begin
      st_o    = st_i;
      cnt_o   = cnt_i;
      tok_o   = '0;
      again_o = 1'b0;
      do_arg  = 1'b0;
      arg_v   = 8'd0;

      case (st_i.phase)
         mrt_pkg::PH_OP: begin
            if (cnt_i >= CNT_W'(MAX_COMMANDS)) begin
               st_o.err      = mrt_pkg::STATUS_TOO_MANY;
               st_o.phase    = mrt_pkg::PH_ERR;
               st_o.esc_fill = mrt_pkg::ESC_IDLE;
            end else if (byte_i == mrt_pkg::CH_SPACE || byte_i == mrt_pkg::CH_TAB) begin
               st_o.phase = mrt_pkg::PH_OP;
            end else if (byte_i == mrt_pkg::CH_HASH) begin
               st_o.phase = mrt_pkg::PH_COMMENT;
            end else if (op_idx == mrt_pkg::OP_NONE) begin
               st_o.err      = mrt_pkg::STATUS_UNSUP;
               st_o.phase    = mrt_pkg::PH_ERR;
               st_o.esc_fill = mrt_pkg::ESC_IDLE;
            end else if (op_idx == mrt_pkg::OP_COLON) begin
               st_o.phase = mrt_pkg::PH_OP;
            end else if (new_shape == mrt_pkg::SH_NONE) begin
               tok_o.valid = 1'b1;
               tok_o.op    = op_idx;
               cnt_o       = CNT_W'(cnt_i + 1'b1);
            end else begin
               st_o.pending_op = op_idx;
               if (new_shape == mrt_pkg::SH_C || new_shape == mrt_pkg::SH_CC) begin
                  st_o.phase = mrt_pkg::PH_CHAR1;
               end else begin
                  st_o.phase = mrt_pkg::PH_POS1;
               end
            end
         end
         mrt_pkg::PH_POS1, mrt_pkg::PH_POS2: begin
            do_arg = 1'b1;
            arg_v  = pos_v;
         end
         mrt_pkg::PH_CHAR1, mrt_pkg::PH_CHAR2: begin
            case (st_i.esc_fill)
               mrt_pkg::ESC_IDLE: begin
                  if (byte_i == mrt_pkg::CH_BSLASH && !last_i) begin
                     st_o.esc_fill = mrt_pkg::ESC_SLASH;
                  end else begin
                     do_arg = 1'b1;
                     arg_v  = byte_i;
                  end
               end
               mrt_pkg::ESC_SLASH: begin
                  st_o.esc_fill = mrt_pkg::ESC_IDLE;
                  if (byte_i == mrt_pkg::CH_X) begin
                     if (last_i) begin
                        do_arg = 1'b1;
                        arg_v  = mrt_pkg::CH_X;
                     end else begin
                        st_o.esc_fill = mrt_pkg::ESC_HEX0;
                     end
                  end else begin
                     do_arg = 1'b1;
                     if (byte_i == mrt_pkg::CH_T) begin
                        arg_v = mrt_pkg::CH_TAB;
                     end else if (byte_i == mrt_pkg::CH_R) begin
                        arg_v = mrt_pkg::BYTE_CR;
                     end else if (byte_i == mrt_pkg::CH_N) begin
                        arg_v = mrt_pkg::BYTE_LF;
                     end else if (byte_i == mrt_pkg::CH_ZERO) begin
                        arg_v = mrt_pkg::BYTE_NUL;
                     end else begin
                        arg_v = byte_i;
                     end
                  end
               end
               mrt_pkg::ESC_HEX0: begin
                  if (last_i) begin
                     // The line ends one byte into a hex escape: take 'x' and rerun this byte.
                     st_o.esc_fill = mrt_pkg::ESC_IDLE;
                     do_arg        = 1'b1;
                     arg_v         = mrt_pkg::CH_X;
                     again_o       = 1'b1;
                  end else begin
                     st_o.esc_byte = byte_i;
                     st_o.esc_fill = mrt_pkg::ESC_HEX1;
                  end
               end
               default: begin
                  st_o.esc_fill = mrt_pkg::ESC_IDLE;
                  if (hex_hi[4] || hex_lo[4]) begin
                     st_o.err   = mrt_pkg::STATUS_MALFORM;
                     st_o.phase = mrt_pkg::PH_ERR;
                  end else begin
                     do_arg = 1'b1;
                     arg_v  = {hex_hi[3:0], hex_lo[3:0]};
                  end
               end
            endcase
         end
         default: begin
            st_o = st_i;
         end
      endcase

      if (do_arg) begin
         if (st_i.phase == mrt_pkg::PH_POS1 && pend_shape == mrt_pkg::SH_PP) begin
            st_o.held_arg = arg_v;
            st_o.phase    = mrt_pkg::PH_POS2;
         end else if (st_i.phase == mrt_pkg::PH_POS1 && pend_shape == mrt_pkg::SH_PC) begin
            st_o.held_arg = arg_v;
            st_o.phase    = mrt_pkg::PH_CHAR2;
         end else if (st_i.phase == mrt_pkg::PH_CHAR1 && pend_shape == mrt_pkg::SH_CC) begin
            st_o.held_arg = arg_v;
            st_o.phase    = mrt_pkg::PH_CHAR2;
         end else begin
            tok_o.valid = 1'b1;
            tok_o.op    = st_i.pending_op;
            if (st_i.phase == mrt_pkg::PH_POS2 || st_i.phase == mrt_pkg::PH_CHAR2) begin
               tok_o.arg_one = st_i.held_arg;
               tok_o.arg_two = arg_v;
            end else begin
               tok_o.arg_one = arg_v;
               tok_o.arg_two = 8'd0;
            end
            cnt_o      = CNT_W'(cnt_i + 1'b1);
            st_o.phase = mrt_pkg::PH_OP;
         end
      end
   end

endmodule

// ===== rtl/mangling_rule_tokenizer.sv =====
// Top level of the mangling-rule tokenizer: line state, parsing steps and result staging.
//
//   Channel   Direction  Payload
//   req_      in         rule_byte, line_end
//   rsp_      out        kind, opcode, arg_one, arg_two, status, final_res
//
// One byte is taken per cycle while not stalled; its first result is registered next cycle.
// A byte with two results occupies the spare result slot; the next byte waits until it empties.
// Without stalls, one byte per cycle: the parse before the result register is combinational.
// Synchronous reset returns the line state to an empty line and empties both result slots.
// req_stall is raised while the spare slot is full or the result register is held by rsp_stall.
module mangling_rule_tokenizer #(
   parameter int MAX_COMMANDS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rule_byte,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [5:0] rsp_opcode,
   output logic [7:0] rsp_arg_one,
   output logic [7:0] rsp_arg_two,
   output logic [1:0] rsp_status,
   output logic       rsp_final_res
);

   localparam int CNT_W = $clog2(MAX_COMMANDS + 1);

   mrt_pkg::line_state_type st_ff, st_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   mrt_pkg::result_type     out_ff, out_in;
   logic                    out_v_ff, out_v_in;
   mrt_pkg::result_type     extra_ff, extra_in;
   logic                    extra_v_ff, extra_v_in;

   mrt_pkg::line_state_type st_a, st_b, st_fin;
   logic [CNT_W-1:0]        cnt_a, cnt_b, cnt_fin;
   mrt_pkg::token_type      tok_a, tok_b, tok_b_eff, tok_first, tok_second;
   logic                    again_a, again_b;
   logic [1:0]              ntok;
   logic [1:0]              err_line;
   mrt_pkg::result_type     res0, res1, stat_res;
   logic [1:0]              nres;
   logic                    accept, drain;

   mrt_feed #(.MAX_COMMANDS(MAX_COMMANDS), .CNT_W(CNT_W)) u_feed_a (
      .st_i    (st_ff),
      .cnt_i   (cnt_ff),
      .byte_i  (req_rule_byte),
      .last_i  (req_line_end),
      .st_o    (st_a),
      .cnt_o   (cnt_a),
      .tok_o   (tok_a),
      .again_o (again_a)
   );

   mrt_feed #(.MAX_COMMANDS(MAX_COMMANDS), .CNT_W(CNT_W)) u_feed_b (
      .st_i    (st_a),
      .cnt_i   (cnt_a),
      .byte_i  (req_rule_byte),
      .last_i  (1'b1),
      .st_o    (st_b),
      .cnt_o   (cnt_b),
      .tok_o   (tok_b),
      .again_o (again_b)
   );

   assign req_stall = extra_v_ff || (out_v_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign drain     = out_v_ff && !rsp_stall;

   always_comb begin
      tok_b_eff  = (again_a && !again_b) ? tok_b : '0;
      st_fin     = again_a ? st_b : st_a;
      cnt_fin    = again_a ? cnt_b : cnt_a;
      ntok       = 2'(tok_a.valid) + 2'(tok_b_eff.valid);
      tok_first  = tok_a.valid ? tok_a : tok_b_eff;
      tok_second = tok_b_eff;

      err_line = st_fin.err;
      if (err_line == mrt_pkg::STATUS_OK && st_fin.phase != mrt_pkg::PH_OP &&
          st_fin.phase != mrt_pkg::PH_COMMENT) begin
         err_line = mrt_pkg::STATUS_MALFORM;
      end

      stat_res           = '0;
      stat_res.kind      = 1'b1;
      stat_res.status    = err_line;
      stat_res.final_res = 1'b1;

      res0         = '0;
      res0.opcode  = tok_first.op;
      res0.arg_one = tok_first.arg_one;
      res0.arg_two = tok_first.arg_two;
      res1         = '0;
      res1.opcode  = tok_second.op;
      res1.arg_one = tok_second.arg_one;
      res1.arg_two = tok_second.arg_two;
      nres         = ntok;

      if (!req_line_end) begin
         if (st_fin.err != mrt_pkg::STATUS_OK) begin
            nres = 2'd0;
         end
      end else if (err_line != mrt_pkg::STATUS_OK) begin
         res0 = stat_res;
         nres = 2'd1;
      end else if (ntok == 2'd2) begin
         res1.final_res = 1'b1;
      end else if (ntok == 2'd1) begin
         res1 = stat_res;
         nres = 2'd2;
      end else begin
         res0 = stat_res;
         nres = 2'd1;
      end

      st_in      = st_ff;
      cnt_in     = cnt_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff;
      extra_in   = extra_ff;
      extra_v_in = extra_v_ff;

      if (accept) begin
         if (req_line_end) begin
            st_in  = '{phase: mrt_pkg::PH_OP, default: '0};
            cnt_in = '0;
         end else begin
            st_in  = st_fin;
            cnt_in = cnt_fin;
         end
         out_in     = res0;
         out_v_in   = (nres != 2'd0);
         extra_in   = res1;
         extra_v_in = (nres == 2'd2);
      end else if (drain) begin
         out_in     = extra_ff;
         out_v_in   = extra_v_ff;
         extra_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= '{phase: mrt_pkg::PH_OP, default: '0};
         cnt_ff     <= '0;
         out_v_ff   <= 1'b0;
         extra_v_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         cnt_ff     <= cnt_in;
         out_v_ff   <= out_v_in;
         extra_v_ff <= extra_v_in;
      end
      out_ff   <= out_in;
      extra_ff <= extra_in;
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_kind      = out_ff.kind;
   assign rsp_opcode    = out_ff.opcode;
   assign rsp_arg_one   = out_ff.arg_one;
   assign rsp_arg_two   = out_ff.arg_two;
   assign rsp_status    = out_ff.status;
   assign rsp_final_res = out_ff.final_res;

endmodule

// ===== rtl/mrt_checker.sv =====
// Port-level checker for the mangling-rule tokenizer and its bind statement.
module mrt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kind,
   input logic [5:0] rsp_opcode,
   input logic [7:0] rsp_arg_one,
   input logic [7:0] rsp_arg_two,
   input logic [1:0] rsp_status,
   input logic       rsp_final_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_opcode) &&
      $stable(rsp_arg_one) && $stable(rsp_arg_two) && $stable(rsp_status) &&
      $stable(rsp_final_res))
      else $error("Stalled transaction changed on the result channel.");

   a_status_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_final_res && rsp_opcode == 6'd0 &&
      rsp_arg_one == 8'd0 && rsp_arg_two == 8'd0)
      else $error("Status transaction is not a clean end-of-line result.");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> rsp_status == 2'd0)
      else $error("Nonzero status before the end of a line.");

   a_token_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_opcode != 6'd0 && rsp_opcode <= 6'd47 &&
      rsp_status == 2'd0)
      else $error("Command token carries an invalid opcode or a status.");

endmodule

bind mangling_rule_tokenizer mrt_checker u_mrt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_opcode    (rsp_opcode),
   .rsp_arg_one   (rsp_arg_one),
   .rsp_arg_two   (rsp_arg_two),
   .rsp_status    (rsp_status),
   .rsp_final_res (rsp_final_res)
);

// ===== sim/rule_token_checker.sv =====
// Checker for the mangling-rule tokenizer: predicts the tokens of each accepted byte and compares.
module rule_token_checker #(
   parameter int CMD_LIMIT = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rule_byte,
   input  logic       req_line_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_kind,
   input  logic [5:0] rsp_opcode,
   input  logic [7:0] rsp_arg_one,
   input  logic [7:0] rsp_arg_two,
   input  logic [1:0] rsp_status,
   input  logic       rsp_final_res,
   output int         error_count,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [8*mrt_pkg::NUM_OPS-1:0] OP_CHARS =
      ":lucrd[]Tt$^D+-.,*LR{}kKqsEfoiOICp'xyY@zZ<>_!/()";

   localparam mrt_pkg::shape_type ARG_FORM [mrt_pkg::NUM_OPS] = '{
      mrt_pkg::SH_NONE, mrt_pkg::SH_NONE, mrt_pkg::SH_NONE, mrt_pkg::SH_NONE,
      mrt_pkg::SH_NONE, mrt_pkg::SH_NONE, mrt_pkg::SH_NONE, mrt_pkg::SH_NONE,
      mrt_pkg::SH_P,    mrt_pkg::SH_NONE, mrt_pkg::SH_C,    mrt_pkg::SH_C,
      mrt_pkg::SH_P,    mrt_pkg::SH_P,    mrt_pkg::SH_P,    mrt_pkg::SH_P,
      mrt_pkg::SH_P,    mrt_pkg::SH_PP,   mrt_pkg::SH_P,    mrt_pkg::SH_P,
      mrt_pkg::SH_NONE, mrt_pkg::SH_NONE, mrt_pkg::SH_NONE, mrt_pkg::SH_NONE,
      mrt_pkg::SH_NONE, mrt_pkg::SH_CC,   mrt_pkg::SH_NONE, mrt_pkg::SH_NONE,
      mrt_pkg::SH_PC,   mrt_pkg::SH_PC,   mrt_pkg::SH_PP,   mrt_pkg::SH_PC,
      mrt_pkg::SH_NONE, mrt_pkg::SH_P,    mrt_pkg::SH_P,    mrt_pkg::SH_PP,
      mrt_pkg::SH_P,    mrt_pkg::SH_P,    mrt_pkg::SH_C,    mrt_pkg::SH_P,
      mrt_pkg::SH_P,    mrt_pkg::SH_P,    mrt_pkg::SH_P,    mrt_pkg::SH_P,
      mrt_pkg::SH_C,    mrt_pkg::SH_C,    mrt_pkg::SH_C,    mrt_pkg::SH_C
   };

   mrt_pkg::phase_type  line_phase;
   logic [5:0]          line_op;
   logic [7:0]          line_held;
   logic [7:0]          line_hex_hi;
   logic [1:0]          line_esc;
   logic [7:0]          line_cmds;
   logic [1:0]          line_status;
   logic [5:0]          tok_op [2];
   logic [7:0]          tok_one [2];
   logic [7:0]          tok_two [2];
   int                  tok_count;
   mrt_pkg::result_type expected_tokens [$];
   int                  mismatches = 0;

   function automatic void clear_line();
      line_phase  = mrt_pkg::PH_OP;
      line_op     = '0;
      line_held   = '0;
      line_hex_hi = '0;
      line_esc    = mrt_pkg::ESC_IDLE;
      line_cmds   = '0;
      line_status = mrt_pkg::STATUS_OK;
      tok_count   = 0;
   endfunction

   function automatic int op_index(logic [7:0] b);
      for (int k = 0; k < mrt_pkg::NUM_OPS; k++) begin
         if (OP_CHARS[8*(mrt_pkg::NUM_OPS-1-k) +: 8] == b) return k;
      end
      return mrt_pkg::NUM_OPS;
   endfunction

   function automatic logic [7:0] base36_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "A" && b <= "Z") return b - "A" + 8'd10;
      if (b >= "a" && b <= "z") return b - "a" + 8'd10;
      return 8'd0;
   endfunction

   function automatic logic [4:0] hex_nibble(logic [7:0] b);
      if (b >= "0" && b <= "9") return 5'(b - "0");
      if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
      if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
      return 5'd16;
   endfunction

   function automatic void flag_error(logic [1:0] code);
      if (line_status == mrt_pkg::STATUS_OK) line_status = code;
      line_phase = mrt_pkg::PH_ERR;
      line_esc   = mrt_pkg::ESC_IDLE;
   endfunction

   function automatic void take_token(logic [5:0] op, logic [7:0] one, logic [7:0] two);
      if (tok_count < 2) begin
         tok_op[tok_count]  = op;
         tok_one[tok_count] = one;
         tok_two[tok_count] = two;
         tok_count++;
      end
      line_cmds  = line_cmds + 8'd1;
      line_phase = mrt_pkg::PH_OP;
   endfunction

   function automatic void finish_arg(logic [7:0] v);
      mrt_pkg::shape_type form;
      form = ARG_FORM[line_op];
      case (line_phase)
         mrt_pkg::PH_POS1: begin
            if (form == mrt_pkg::SH_PP) begin
               line_held  = v;
               line_phase = mrt_pkg::PH_POS2;
            end else if (form == mrt_pkg::SH_PC) begin
               line_held  = v;
               line_phase = mrt_pkg::PH_CHAR2;
            end else begin
               take_token(line_op, v, 8'd0);
            end
         end
         mrt_pkg::PH_CHAR1: begin
            if (form == mrt_pkg::SH_CC) begin
               line_held  = v;
               line_phase = mrt_pkg::PH_CHAR2;
            end else begin
               take_token(line_op, v, 8'd0);
            end
         end
         mrt_pkg::PH_POS2, mrt_pkg::PH_CHAR2: take_token(line_op, line_held, v);
         default: ;
      endcase
   endfunction

   // Returns 1 when a short hex escape at line end leaves the byte to be parsed once more.
   function automatic bit feed_byte(logic [7:0] b, bit last);
      int         op;
      logic [4:0] hi;
      logic [4:0] lo;
      bit         again;
      again = 1'b0;
      op = op_index(b);
      if (line_phase == mrt_pkg::PH_OP) begin
         if (line_cmds >= CMD_LIMIT) begin
            flag_error(mrt_pkg::STATUS_TOO_MANY);
         end else if (b != mrt_pkg::CH_SPACE && b != mrt_pkg::CH_TAB &&
                      op != mrt_pkg::OP_COLON) begin
            if (b == mrt_pkg::CH_HASH) begin
               line_phase = mrt_pkg::PH_COMMENT;
            end else if (op >= mrt_pkg::NUM_OPS) begin
               flag_error(mrt_pkg::STATUS_UNSUP);
            end else if (ARG_FORM[op] == mrt_pkg::SH_NONE) begin
               take_token(op[5:0], 8'd0, 8'd0);
            end else begin
               line_op = op[5:0];
               if (ARG_FORM[op] == mrt_pkg::SH_C || ARG_FORM[op] == mrt_pkg::SH_CC) begin
                  line_phase = mrt_pkg::PH_CHAR1;
               end else begin
                  line_phase = mrt_pkg::PH_POS1;
               end
            end
         end
      end else if (line_phase == mrt_pkg::PH_POS1 || line_phase == mrt_pkg::PH_POS2) begin
         finish_arg(base36_value(b));
      end else if (line_phase == mrt_pkg::PH_CHAR1 || line_phase == mrt_pkg::PH_CHAR2) begin
         case (line_esc)
            mrt_pkg::ESC_IDLE: begin
               if (b == mrt_pkg::CH_BSLASH && !last) line_esc = mrt_pkg::ESC_SLASH;
               else finish_arg(b);
            end
            mrt_pkg::ESC_SLASH: begin
               line_esc = mrt_pkg::ESC_IDLE;
               if (b == mrt_pkg::CH_X) begin
                  if (last) finish_arg(mrt_pkg::CH_X);
                  else line_esc = mrt_pkg::ESC_HEX0;
               end else if (b == mrt_pkg::CH_T) begin
                  finish_arg(mrt_pkg::CH_TAB);
               end else if (b == mrt_pkg::CH_R) begin
                  finish_arg(mrt_pkg::BYTE_CR);
               end else if (b == mrt_pkg::CH_N) begin
                  finish_arg(mrt_pkg::BYTE_LF);
               end else if (b == mrt_pkg::CH_ZERO) begin
                  finish_arg(mrt_pkg::BYTE_NUL);
               end else begin
                  finish_arg(b);
               end
            end
            mrt_pkg::ESC_HEX0: begin
               if (last) begin
                  line_esc = mrt_pkg::ESC_IDLE;
                  finish_arg(mrt_pkg::CH_X);
                  again = 1'b1;
               end else begin
                  line_hex_hi = b;
                  line_esc = mrt_pkg::ESC_HEX1;
               end
            end
            default: begin
               line_esc = mrt_pkg::ESC_IDLE;
               hi = hex_nibble(line_hex_hi);
               lo = hex_nibble(b);
               if (hi[4] || lo[4]) flag_error(mrt_pkg::STATUS_MALFORM);
               else finish_arg({hi[3:0], lo[3:0]});
            end
         endcase
      end
      return again;
   endfunction

   function automatic void tokenize_byte(logic [7:0] b, bit last);
      mrt_pkg::result_type res;
      bit again;
      tok_count = 0;
      again = feed_byte(b, last);
      if (again) again = feed_byte(b, 1'b1);
      if (last && line_status == mrt_pkg::STATUS_OK && line_phase != mrt_pkg::PH_OP &&
          line_phase != mrt_pkg::PH_COMMENT)
         line_status = mrt_pkg::STATUS_MALFORM;
      if (line_status == mrt_pkg::STATUS_OK) begin
         for (int k = 0; k < tok_count; k++) begin
            res = '0;
            res.opcode    = tok_op[k];
            res.arg_one   = tok_one[k];
            res.arg_two   = tok_two[k];
            res.final_res = last && k == 1;
            expected_tokens.insert(expected_tokens.size(), res);
         end
      end
      if (last) begin
         if (line_status != mrt_pkg::STATUS_OK || tok_count < 2) begin
            res = '0;
            res.kind      = 1'b1;
            res.status    = line_status;
            res.final_res = 1'b1;
            expected_tokens.insert(expected_tokens.size(), res);
         end
         clear_line();
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      mrt_pkg::result_type seen;
      mrt_pkg::result_type want;
      if (reset) begin
         clear_line();
         expected_tokens.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_opcode, rsp_arg_one, rsp_arg_two, rsp_status, rsp_final_res};
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("result with none expected: kind %0d opcode %0d status %0d",
                                         seen.kind, seen.opcode, seen.status));
            end else begin
               want = expected_tokens.pop_front();
               compare_field("kind", seen.kind, want.kind);
               compare_field("opcode", seen.opcode, want.opcode);
               compare_field("arg_one", seen.arg_one, want.arg_one);
               compare_field("arg_two", seen.arg_two, want.arg_two);
               compare_field("status", seen.status, want.status);
               compare_field("final_res", seen.final_res, want.final_res);
            end
         end
         if (req_valid && !req_stall) tokenize_byte(req_rule_byte, req_line_end);
      end
      error_count <= mismatches;
      outstanding <= expected_tokens.size();
   end

endmodule

// ===== sim/tb_mangling_rule_tokenizer.sv =====
// Testbench top for the mangling-rule tokenizer: rule-line stimulus, flow control and verdict.
module tb_mangling_rule_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CMD_LIMIT      = 32;
   localparam int BYTE_TARGET    = 1800;
   localparam int IDLE_LIMIT     = 3000;
   localparam int PRESSURE_START = 800;
   localparam int PRESSURE_LEN   = 400;

   localparam logic [7:0] SEPARATORS [3] = '{mrt_pkg::CH_SPACE, mrt_pkg::CH_TAB, ":"};
   localparam logic [7:0] ESC_LETTERS [4] = '{
      mrt_pkg::CH_T, mrt_pkg::CH_R, mrt_pkg::CH_N, mrt_pkg::CH_ZERO
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rule_byte = 8'd0;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [5:0] rsp_opcode;
   logic [7:0] rsp_arg_one;
   logic [7:0] rsp_arg_two;
   logic [1:0] rsp_status;
   logic       rsp_final_res;
   int         error_count;
   int         outstanding;
   int         idle_cycles = 0;
   int         bytes_sent = 0;
   bit         steady_line = 1'b0;
   logic [7:0] line_bytes [$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   mangling_rule_tokenizer #(.MAX_COMMANDS(CMD_LIMIT)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rule_byte(req_rule_byte), .req_line_end(req_line_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind), .rsp_opcode(rsp_opcode),
      .rsp_arg_one(rsp_arg_one), .rsp_arg_two(rsp_arg_two),
      .rsp_status(rsp_status), .rsp_final_res(rsp_final_res)
   );

   rule_token_checker #(.CMD_LIMIT(CMD_LIMIT)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rule_byte(req_rule_byte), .req_line_end(req_line_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind), .rsp_opcode(rsp_opcode),
      .rsp_arg_one(rsp_arg_one), .rsp_arg_two(rsp_arg_two),
      .rsp_status(rsp_status), .rsp_final_res(rsp_final_res),
      .error_count(error_count), .outstanding(outstanding)
   );

   function automatic void append_byte(logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(0, 1) == 1) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   function automatic void add_position();
      logic [7:0] b;
      int v;
      v = $urandom_range(0, 35);
      if (v < 10) b = 8'("0" + v);
      else if ($urandom_range(0, 1) == 1) b = 8'("a" + v - 10);
      else b = 8'("A" + v - 10);
      if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
      append_byte(b);
   endfunction

   function automatic void add_char();
      logic [7:0] b;
      int r;
      r = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      if (r < 50) begin
         if (b == mrt_pkg::CH_BSLASH) append_byte(mrt_pkg::CH_BSLASH);
         append_byte(b);
      end else if (r < 70) begin
         append_byte(mrt_pkg::CH_BSLASH);
         append_byte(mrt_pkg::CH_X);
         append_byte(hex_char());
         append_byte(hex_char());
      end else if (r < 75) begin
         append_byte(mrt_pkg::CH_BSLASH);
         append_byte(mrt_pkg::CH_X);
         append_byte(hex_char());
         append_byte(b);
      end else if (r < 90) begin
         append_byte(mrt_pkg::CH_BSLASH);
         append_byte(ESC_LETTERS[$urandom_range(0, 3)]);
      end else begin
         append_byte(mrt_pkg::CH_BSLASH);
         append_byte(b);
      end
   endfunction

   function automatic void add_command();
      int op;
      op = $urandom_range(1, mrt_pkg::NUM_OPS - 1);
      append_byte(mrt_pkg::OP_BYTE[op]);
      case (mrt_pkg::OP_SHAPE[op])
         mrt_pkg::SH_P: add_position();
         mrt_pkg::SH_PP: begin
            add_position();
            add_position();
         end
         mrt_pkg::SH_C: add_char();
         mrt_pkg::SH_CC: begin
            add_char();
            add_char();
         end
         mrt_pkg::SH_PC: begin
            add_position();
            add_char();
         end
         default: ;
      endcase
   endfunction

   // Mostly well-formed lines; some are pure noise, cut short or have one byte corrupted.
   function automatic void build_random_line();
      logic [7:0] noise;
      int flavor;
      int cmds;
      int spot;
      line_bytes.delete();
      flavor = $urandom_range(0, 99);
      if (flavor < 12) begin
         repeat ($urandom_range(1, 8)) begin
            noise = 8'($urandom_range(0, 255));
            append_byte(noise);
         end
      end else begin
         if ($urandom_range(0, 19) == 0) cmds = $urandom_range(CMD_LIMIT - 2, CMD_LIMIT + 2);
         else cmds = $urandom_range(1, 6);
         repeat (cmds) begin
            if ($urandom_range(0, 3) == 0) append_byte(SEPARATORS[$urandom_range(0, 2)]);
            add_command();
         end
         if ($urandom_range(0, 9) == 0) begin
            append_byte(mrt_pkg::CH_HASH);
            repeat ($urandom_range(0, 4)) begin
               noise = 8'($urandom_range(0, 255));
               append_byte(noise);
            end
         end
         if (flavor < 20 && line_bytes.size() > 2) begin
            repeat ($urandom_range(1, 2)) line_bytes.delete(line_bytes.size() - 1);
         end else if (flavor < 26) begin
            spot = $urandom_range(0, line_bytes.size() - 1);
            noise = 8'($urandom_range(0, 255));
            line_bytes[spot] = noise;
         end
      end
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      gap = steady_line ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rule_byte <= b;
      req_line_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_line();
      for (int k = 0; k < line_bytes.size(); k++) begin
         send_byte(line_bytes[k], k == line_bytes.size() - 1);
      end
   endtask

   task automatic send_text(string text);
      line_bytes.delete();
      for (int k = 0; k < text.len(); k++) append_byte(text[k]);
      send_line();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_text("$\\x");
      send_text("$\\xl");
      send_text("^\\");
      send_text("$\\xzz");
      send_text("a");
      send_text("T");
      send_text("u#q");
      send_text("*0Z");
      send_text("o3\\xFF");
      send_text(":");
      while (bytes_sent < BYTE_TARGET) begin
         build_random_line();
         steady_line = ($urandom_range(0, 3) == 0);
         send_line();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // The receiver stalls in bursts, and once holds off long enough for the block to back up.
   initial begin : receiver
      int elapsed;
      int hold;
      int free;
      bit pressed;
      elapsed = 0;
      pressed = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!pressed && elapsed >= PRESSURE_START) begin
            hold = PRESSURE_LEN;
            pressed = 1'b1;
         end else begin
            hold = gap_length();
         end
         free = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (free) @(posedge clock);
         elapsed += hold + free;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
rtl/mrt_pkg.sv
rtl/mrt_feed.sv
rtl/mangling_rule_tokenizer.sv
rtl/mrt_checker.sv
sim/rule_token_checker.sv
sim/tb_mangling_rule_tokenizer.sv
